>>> hdl/nll_pkg.sv
package nll_pkg;

    localparam int unsigned CHAR_W = 8;

    typedef enum logic [1:0] {
        ST_CONT = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2,
        ST_IDLE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_INT   = 2'd1,
        KIND_FLOAT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_UNKNOWN_BASE = 3'd1,
        ERR_TWO_EXP      = 3'd2,
        ERR_POINT        = 3'd3,
        ERR_FLOAT_LONG   = 3'd4,
        ERR_FLOAT_UNS    = 3'd5,
        ERR_START        = 3'd6
    } t_error;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

endpackage

>>> hdl/nll_if.sv
interface nll_in_if;
    logic                       valid;
    logic                       ready;
    logic [nll_pkg::CHAR_W-1:0] char_in;
    logic                       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface nll_out_if;
    logic             valid;
    logic             ready;
    logic             consumed;
    nll_pkg::t_status status;
    nll_pkg::t_kind   literal_kind;
    nll_pkg::t_error  error_code;

    modport source (output valid, output consumed, output status, output literal_kind,
                    output error_code, input ready);
    modport sink   (input valid, input consumed, input status, input literal_kind,
                    input error_code, output ready);
endinterface

>>> hdl/numeric_literal_lexer_unit.sv
// Numeric literal lexer: classifies one lookahead character per transaction.
// i_in carries char_in and end_of_input; o_out returns one result per input
// transaction: consumed, status (continuing, finished, error, idle), the
// literal kind on finish and an error code on error.
// Feed the leading digit while idle, then each following character. A
// character that ends the literal comes back with consumed low and must be
// presented again as the start of the next token.
// The scan state updates and the result register loads at the edge where the
// input transaction completes. Throughput is one character per cycle while
// the receiver takes each result, set by the single result register; i_in.ready
// stays high while that register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and i_in.ready drops until it
// is taken.
// Reset (synchronous, active low) returns the scanner to idle in base 10 with
// all flags clear and empties the result register.
module numeric_literal_lexer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nll_in_if.sink     i_in,
    nll_out_if.source  o_out
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ZERO = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_BIN = 2'd1,
        BASE_OCT = 2'd2,
        BASE_HEX = 2'd3
    } t_base;

    t_phase r_phase, n_phase;
    t_base  r_base, n_base;
    logic   r_float, n_float;
    logic   r_exp, n_exp;
    logic   r_minus, n_minus;
    logic   r_uns, n_uns;
    logic   r_long, n_long;

    logic             r_out_valid;
    logic             r_cons, n_cons;
    nll_pkg::t_status r_stat, n_stat;
    nll_pkg::t_kind   r_kind, n_kind;
    nll_pkg::t_error  r_err, n_err;

    logic                       in_fire;
    logic [nll_pkg::CHAR_W-1:0] ch;
    logic                       eoi;
    logic                       is_dec;
    logic                       do_body;
    nll_pkg::t_kind             fin_kind;

    assign ch      = i_in.char_in;
    assign eoi     = i_in.end_of_input;
    assign is_dec  = (ch >= nll_pkg::CH_0) && (ch <= nll_pkg::CH_9);
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire = i_in.valid && i_in.ready;

    always_comb begin
        if (r_float) begin
            fin_kind = nll_pkg::KIND_FLOAT;
        end else if (r_uns || r_long || (r_base != BASE_DEC)) begin
            fin_kind = nll_pkg::KIND_INT;
        end else begin
            fin_kind = nll_pkg::KIND_PLAIN;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_base  = r_base;
        n_float = r_float;
        n_exp   = r_exp;
        n_minus = r_minus;
        n_uns   = r_uns;
        n_long  = r_long;
        n_cons  = 1'b0;
        n_stat  = nll_pkg::ST_IDLE;
        n_kind  = nll_pkg::KIND_PLAIN;
        n_err   = nll_pkg::ERR_NONE;
        do_body = 1'b0;

        unique case (r_phase)
            PH_ZERO: begin
                if (eoi) begin
                    n_phase = PH_IDLE;
                    n_stat  = nll_pkg::ST_DONE;
                    n_kind  = fin_kind;
                end else if (is_dec || ch == nll_pkg::CH_E_LO || ch == nll_pkg::CH_E_UP
                             || ch == nll_pkg::CH_POINT) begin
                    do_body = 1'b1;
                end else if (ch == nll_pkg::CH_B || ch == nll_pkg::CH_O
                             || ch == nll_pkg::CH_X) begin
                    n_base  = (ch == nll_pkg::CH_B) ? BASE_BIN :
                              (ch == nll_pkg::CH_O) ? BASE_OCT : BASE_HEX;
                    n_phase = PH_BODY;
                    n_cons  = 1'b1;
                    n_stat  = nll_pkg::ST_CONT;
                end else begin
                    n_phase = PH_IDLE;
                    n_cons  = 1'b1;
                    n_stat  = nll_pkg::ST_ERR;
                    n_err   = nll_pkg::ERR_UNKNOWN_BASE;
                end
            end
            PH_BODY: begin
                if (eoi) begin
                    n_phase = PH_IDLE;
                    n_stat  = nll_pkg::ST_DONE;
                    n_kind  = fin_kind;
                end else begin
                    do_body = 1'b1;
                end
            end
            default: begin
                // unused phase code behaves as idle
                n_phase = PH_IDLE;
                if (eoi) begin
                    n_stat = nll_pkg::ST_IDLE;
                end else if (!is_dec) begin
                    n_stat = nll_pkg::ST_ERR;
                    n_err  = nll_pkg::ERR_START;
                end else begin
                    n_base  = BASE_DEC;
                    n_float = 1'b0;
                    n_exp   = 1'b0;
                    n_minus = 1'b0;
                    n_uns   = 1'b0;
                    n_long  = 1'b0;
                    n_phase = (ch == nll_pkg::CH_0) ? PH_ZERO : PH_BODY;
                    n_cons  = 1'b1;
                    n_stat  = nll_pkg::ST_CONT;
                end
            end
        endcase

        if (do_body) begin
            // default to finish; taking and failing override below
            n_phase = PH_IDLE;
            n_stat  = nll_pkg::ST_DONE;
            n_kind  = fin_kind;
            if (r_uns && r_long) begin
                // both suffixes present: any character ends the literal
            end else if (r_uns) begin
                if (ch == nll_pkg::CH_L) begin
                    n_long = 1'b1;
                    n_cons = 1'b1;
                end
            end else if (r_long) begin
                if (ch == nll_pkg::CH_U) begin
                    n_uns  = 1'b1;
                    n_cons = 1'b1;
                end
            end else begin
                unique case (r_base)
                    BASE_BIN: begin
                        n_cons = (ch == nll_pkg::CH_0) || (ch == nll_pkg::CH_1);
                    end
                    BASE_OCT: begin
                        n_cons = (ch >= nll_pkg::CH_0) && (ch <= nll_pkg::CH_7);
                    end
                    BASE_HEX: begin
                        n_cons = is_dec
                            || ((ch >= nll_pkg::CH_A_LO) && (ch <= nll_pkg::CH_F_LO))
                            || ((ch >= nll_pkg::CH_A_UP) && (ch <= nll_pkg::CH_F_UP));
                    end
                    default: begin
                        if (is_dec) begin
                            n_minus = 1'b0;
                            n_cons  = 1'b1;
                        end else begin
                            case (ch) inside
                                nll_pkg::CH_E_LO, nll_pkg::CH_E_UP: begin
                                    if (r_exp) begin
                                        n_err = nll_pkg::ERR_TWO_EXP;
                                    end else begin
                                        n_exp   = 1'b1;
                                        n_float = 1'b1;
                                        n_minus = 1'b1;
                                        n_cons  = 1'b1;
                                    end
                                end
                                nll_pkg::CH_POINT: begin
                                    if (r_float) begin
                                        n_err = nll_pkg::ERR_POINT;
                                    end else begin
                                        n_float = 1'b1;
                                        n_minus = 1'b0;
                                        n_cons  = 1'b1;
                                    end
                                end
                                nll_pkg::CH_L: begin
                                    if (r_float) begin
                                        n_err = nll_pkg::ERR_FLOAT_LONG;
                                    end else begin
                                        n_long  = 1'b1;
                                        n_minus = 1'b0;
                                        n_cons  = 1'b1;
                                    end
                                end
                                nll_pkg::CH_U: begin
                                    if (r_float) begin
                                        n_err = nll_pkg::ERR_FLOAT_UNS;
                                    end else begin
                                        n_uns   = 1'b1;
                                        n_minus = 1'b0;
                                        n_cons  = 1'b1;
                                    end
                                end
                                nll_pkg::CH_MINUS: begin
                                    if (r_minus) begin
                                        n_minus = 1'b0;
                                        n_cons  = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                endcase
            end

            if (n_err != nll_pkg::ERR_NONE) begin
                n_cons = 1'b1;
                n_stat = nll_pkg::ST_ERR;
                n_kind = nll_pkg::KIND_PLAIN;
            end else if (n_cons) begin
                n_phase = PH_BODY;
                n_stat  = nll_pkg::ST_CONT;
                n_kind  = nll_pkg::KIND_PLAIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_base      <= BASE_DEC;
            r_float     <= 1'b0;
            r_exp       <= 1'b0;
            r_minus     <= 1'b0;
            r_uns       <= 1'b0;
            r_long      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase     <= n_phase;
                r_base      <= n_base;
                r_float     <= n_float;
                r_exp       <= n_exp;
                r_minus     <= n_minus;
                r_uns       <= n_uns;
                r_long      <= n_long;
                r_out_valid <= 1'b1;
                r_cons      <= n_cons;
                r_stat      <= n_stat;
                r_kind      <= n_kind;
                r_err       <= n_err;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.consumed     = r_cons;
    assign o_out.status       = r_stat;
    assign o_out.literal_kind = r_kind;
    assign o_out.error_code   = r_err;

    a_done_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_stat == nll_pkg::ST_DONE) |-> !r_cons)
        else $error("finished literal reports its ending character as consumed");

    a_error_code_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_err != nll_pkg::ERR_NONE) == (r_stat == nll_pkg::ST_ERR)))
        else $error("error code disagrees with status");

    a_end_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_stat != nll_pkg::ST_CONT) |=> (r_phase == PH_IDLE))
        else $error("scanner not idle after literal end or error");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted transaction produced no result");

endmodule
